@@ src/descriptor_ratio_test_matcher_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef DESCRIPTOR_RATIO_TEST_MATCHER_CORE_MACROS_SVH
`define DESCRIPTOR_RATIO_TEST_MATCHER_CORE_MACROS_SVH
// Implication checked every cycle outside reset.
`define DRTM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define DRTM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ src/drtm_pkg.sv @@
// Shared constants, types and helpers of the descriptor matcher.
package drtm_pkg;
  localparam int MaxRefs   = 1024;
  localparam int DescWords = 4;
  localparam int IdxW      = 10;
  localparam int WordIdxW  = 2;
  localparam int CountW    = 11;
  localparam int DistW     = 21;
  localparam int Lanes     = 4;
  localparam int AddrW     = 10;
  localparam int WordW     = 64;
  localparam int WordDistW = 19;
  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic CmdStore = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle, StScan, StDrain, StOut
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] index;
    logic [DistW-1:0] dsq;
  } cand_t;

  typedef struct packed {
    logic start;
    logic last;
  } scan_ctl_t;

  function automatic logic [WordDistW-1:0] word_dist(input logic [WordW-1:0] a,
                                                     input logic [WordW-1:0] b);
    logic [WordDistW-1:0] s;
    logic signed [8:0] d;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      d = $signed({1'b0, a[8*k +: 8]}) - $signed({1'b0, b[8*k +: 8]});
      s = s + WordDistW'(d * d);
    end
    return s;
  endfunction
endpackage

@@ src/drtm_if.sv @@
// Valid/ready channel interfaces for the matcher.
interface drtm_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [drtm_pkg::IdxW-1:0] entry_index;
  logic [drtm_pkg::WordIdxW-1:0] word_index;
  logic [drtm_pkg::WordW-1:0] descriptor_word;
  modport source (output valid, cmd, entry_index, word_index, descriptor_word, input ready);
  modport sink (input valid, cmd, entry_index, word_index, descriptor_word, output ready);
endinterface

interface drtm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic [drtm_pkg::IdxW-1:0] best_index;
  logic [drtm_pkg::DistW-1:0] best_distance_sq;
  logic [drtm_pkg::DistW-1:0] second_distance_sq;
  logic second_present;
  modport source (output valid, matched, best_index, best_distance_sq,
                  second_distance_sq, second_present, input ready);
  modport sink (input valid, matched, best_index, best_distance_sq,
                second_distance_sq, second_present, output ready);
endinterface

@@ src/drtm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module drtm_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/drtm_lane.sv @@
// One distance lane: a word-wide RAM bank and its sum of squared byte differences.
module drtm_lane (
  input  logic                             clk,
  input  logic                             we,
  input  logic [drtm_pkg::AddrW-1:0]       waddr,
  input  logic [drtm_pkg::WordW-1:0]       wdata,
  input  logic [drtm_pkg::AddrW-1:0]       raddr,
  input  logic [drtm_pkg::WordW-1:0]       query,
  output logic [drtm_pkg::WordDistW-1:0]   dist_r
);
  logic [drtm_pkg::WordW-1:0] rdata;

  drtm_ram #(.Width(drtm_pkg::WordW), .Depth(drtm_pkg::MaxRefs)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_ff @(posedge clk) begin
    dist_r <= drtm_pkg::word_dist(query, rdata);
  end
endmodule

@@ src/drtm_merge.sv @@
// Sum the lane distances and keep the nearest and second-nearest entries.
module drtm_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  drtm_pkg::scan_ctl_t                             ctl,
  input  logic [drtm_pkg::IdxW-1:0]                       idx,
  input  logic [drtm_pkg::Lanes-1:0][drtm_pkg::WordDistW-1:0] lane_dist,
  output drtm_pkg::cand_t                                 best_r,
  output drtm_pkg::cand_t                                 second_r
);
  logic [drtm_pkg::DistW:0] sum;
  logic [drtm_pkg::DistW-1:0] d;
  drtm_pkg::cand_t best_nxt, second_nxt;

  always_comb begin
    sum = '0;
    for (int l = 0; l < drtm_pkg::Lanes; l++) begin
      sum = sum + (drtm_pkg::DistW+1)'(lane_dist[l]);
    end
    d = sum[drtm_pkg::DistW] ? drtm_pkg::DistMax : sum[drtm_pkg::DistW-1:0];
  end

  always_comb begin
    best_nxt   = best_r;
    second_nxt = second_r;
    if (ctl.start) begin
      best_nxt   = '0;
      second_nxt = '0;
    end else if (ctl.last) begin
      if (!best_r.valid || d < best_r.dsq) begin
        second_nxt = best_r;
        best_nxt   = '{valid: 1'b1, index: idx, dsq: d};
      end else if (!second_r.valid || d < second_r.dsq) begin
        second_nxt = '{valid: 1'b1, index: idx, dsq: d};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r   <= '0;
      second_r <= '0;
    end else begin
      best_r   <= best_nxt;
      second_r <= second_nxt;
    end
  end
endmodule

@@ src/descriptor_ratio_test_matcher_core.sv @@
// Descriptor matcher top level: store, lane scan, ratio test and result register.
// Reference words go into four RAM banks, one per descriptor word, so a query
// compares one whole reference per cycle across four lanes. Store words and
// buffered query words are taken only while the core is idle. The last query
// word starts a scan of reference_count entries (saturated to 1024) at one
// entry per cycle; each entry passes the RAM read register and the lane
// distance register before the merge, and the result shows once the scan
// drains. The next request is taken once the result is out.
module descriptor_ratio_test_matcher_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [drtm_pkg::CountW-1:0]       cfg_wdata,
  drtm_in_if.sink                           in_ch,
  drtm_out_if.source                        out_ch
);
  localparam int PipeD = 2;

  drtm_pkg::state_t state_r, state_nxt;
  logic [drtm_pkg::CountW-1:0] count_r;
  logic [drtm_pkg::CountW-1:0] scan_r, scan_nxt;
  logic [drtm_pkg::CountW-1:0] limit_r;
  logic [drtm_pkg::WordW-1:0] query_r [drtm_pkg::DescWords];
  logic [PipeD-1:0] vpipe_r;
  logic [drtm_pkg::IdxW-1:0] ipipe_r [PipeD];
  logic [drtm_pkg::Lanes-1:0][drtm_pkg::WordDistW-1:0] lane_dist;
  drtm_pkg::cand_t best_r, second_r;
  drtm_pkg::scan_ctl_t ctl;
  logic accept, last_query, issue;
  logic [drtm_pkg::DistW+4:0] lhs, rhs;

  assign accept = in_ch.valid && in_ch.ready;
  assign last_query = accept && in_ch.cmd == drtm_pkg::CmdQuery &&
                      in_ch.word_index == drtm_pkg::WordIdxW'(drtm_pkg::DescWords - 1);
  assign issue = state_r == drtm_pkg::StScan && scan_r < limit_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    case (state_r)
      drtm_pkg::StIdle: begin
        if (last_query) begin
          state_nxt = drtm_pkg::StScan;
          scan_nxt  = '0;
        end
      end
      drtm_pkg::StScan: begin
        if (issue) scan_nxt = scan_r + 1'b1;
        else state_nxt = drtm_pkg::StDrain;
      end
      drtm_pkg::StDrain: begin
        if (vpipe_r == '0) state_nxt = drtm_pkg::StOut;
      end
      drtm_pkg::StOut: begin
        if (out_ch.ready) state_nxt = drtm_pkg::StIdle;
      end
      default: state_nxt = drtm_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ch.ready  = state_r == drtm_pkg::StIdle;
    out_ch.valid = state_r == drtm_pkg::StOut;
    ctl.start    = last_query;
    ctl.last     = vpipe_r[PipeD-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drtm_pkg::StIdle;
      count_r <= '0;
      scan_r  <= '0;
      vpipe_r <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      vpipe_r <= {vpipe_r[PipeD-2:0], issue};
      if (cfg_we) count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ipipe_r[0] <= scan_r[drtm_pkg::IdxW-1:0];
    for (int p = 1; p < PipeD; p++) ipipe_r[p] <= ipipe_r[p-1];
    if (last_query) begin
      limit_r <= count_r > drtm_pkg::CountW'(drtm_pkg::MaxRefs) ?
                 drtm_pkg::CountW'(drtm_pkg::MaxRefs) : count_r;
    end
    if (accept && in_ch.cmd == drtm_pkg::CmdQuery) begin
      query_r[in_ch.word_index] <= in_ch.descriptor_word;
    end
  end

  for (genvar l = 0; l < drtm_pkg::Lanes; l++) begin : g_lane
    drtm_lane u_lane (
      .clk,
      .we    (accept && in_ch.cmd == drtm_pkg::CmdStore &&
              in_ch.word_index == drtm_pkg::WordIdxW'(l)),
      .waddr (in_ch.entry_index),
      .wdata (in_ch.descriptor_word),
      .raddr (scan_r[drtm_pkg::AddrW-1:0]),
      .query (query_r[l]),
      .dist_r(lane_dist[l])
    );
  end

  drtm_merge u_merge (
    .clk, .rst_n, .ctl,
    .idx      (ipipe_r[PipeD-1]),
    .lane_dist,
    .best_r, .second_r
  );

  assign lhs = 26'(best_r.dsq) * 26'd25;
  assign rhs = 26'(second_r.dsq) * 26'd16;

  always_comb begin
    out_ch.best_index         = best_r.index;
    out_ch.best_distance_sq   = best_r.dsq;
    out_ch.second_distance_sq = second_r.dsq;
    out_ch.second_present     = second_r.valid;
    out_ch.matched            = best_r.valid && (!second_r.valid || lhs < rhs);
  end
endmodule

@@ src/drtm_checker.sv @@
// Port-level checker for the matcher, bound to the top level.
`include "descriptor_ratio_test_matcher_core_macros.svh"
module drtm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic second_present,
  input logic [drtm_pkg::DistW-1:0] second_distance_sq
);
  `DRTM_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `DRTM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `DRTM_ASSERT_IMP(a_sec0, clk, rst_n, out_valid && !second_present, second_distance_sq == '0, "second distance without second")
  `DRTM_ASSERT_NEXT(a_ret, clk, rst_n, out_valid && out_ready, in_ready, "not idle after result")
endmodule

bind descriptor_ratio_test_matcher_core drtm_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .second_present(out_ch.second_present),
  .second_distance_sq(out_ch.second_distance_sq)
);
